>>> hw/rtl/crfb_pkg.sv
`default_nettype none
package crfb_pkg;

   // store geometry
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int X_W         = $clog2(MAX_WIDTH);
   localparam int Y_W         = $clog2(MAX_HEIGHT);

   // field widths
   localparam int DIM_W   = 9;
   localparam int COORD_W = 12;
   localparam int PIXEL_W = 32;

   localparam logic [PIXEL_W-1:0] BLACK_OPAQUE = 32'hFF00_0000;

   // command codes on req_mode
   localparam logic [1:0] MODE_FILL = 2'd0;
   localparam logic [1:0] MODE_BLIT = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   typedef enum logic [1:0] {
      OP_FILL,
      OP_BLIT,
      OP_READ
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_BLIT
   } state_type;

   // clipped command as queued between front and back
   typedef struct packed {
      op_type               op;
      logic [X_W-1:0]       dest_x;
      logic [Y_W-1:0]       dest_y;
      logic [X_W-1:0]       source_x;
      logic [Y_W-1:0]       source_y;
      logic [X_W-1:0]       width_m1;
      logic [Y_W-1:0]       height_m1;
      logic                 rows_up;
      logic                 cols_left;
      logic                 read_zero;
      logic [PIXEL_W-1:0]   color;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage
`default_nettype wire

>>> hw/rtl/crfb_ram.sv
`default_nettype none
module crfb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> hw/rtl/crfb_front.sv
`default_nettype none
module crfb_front
   import crfb_pkg::*;
(
   input  wire logic               accept,
   input  wire logic [1:0]         mode,
   input  wire logic [COORD_W-1:0] dest_x,
   input  wire logic [COORD_W-1:0] dest_y,
   input  wire logic [COORD_W-1:0] source_x,
   input  wire logic [COORD_W-1:0] source_y,
   input  wire logic [COORD_W-1:0] rect_width,
   input  wire logic [COORD_W-1:0] rect_height,
   input  wire logic [PIXEL_W-1:0] fill_color,
   input  wire logic [DIM_W-1:0]   surface_width,
   input  wire logic [DIM_W-1:0]   surface_height,
   output logic                    push,
   output cmd_type                 cmd
);

   localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_HEIGHT);

   logic [DIM_W-1:0] w_eff, h_eff;
   logic             dest_in, src_in;
   logic [DIM_W-1:0] dx_room, dy_room, sx_room, sy_room;
   logic [DIM_W-1:0] x_room, y_room;
   logic [DIM_W-1:0] clip_w, clip_h;
   logic [DIM_W-1:0] clip_w_m1, clip_h_m1;
   logic             is_blit;
   logic             keep;

   // a register above the store size works as the store size
   assign w_eff = (surface_width > MAX_W) ? MAX_W : surface_width;
   assign h_eff = (surface_height > MAX_H) ? MAX_H : surface_height;

   assign dest_in = (dest_x < COORD_W'(w_eff)) && (dest_y < COORD_W'(h_eff));
   assign src_in  = (source_x < COORD_W'(w_eff)) && (source_y < COORD_W'(h_eff));

   // room left to the surface edge, meaningful only for an origin inside
   assign dx_room = w_eff - dest_x[DIM_W-1:0];
   assign dy_room = h_eff - dest_y[DIM_W-1:0];
   assign sx_room = w_eff - source_x[DIM_W-1:0];
   assign sy_room = h_eff - source_y[DIM_W-1:0];

   assign is_blit = (mode == MODE_BLIT);

   // blit clips against both rectangles, fill only against the destination
   assign x_room = (is_blit && (sx_room < dx_room)) ? sx_room : dx_room;
   assign y_room = (is_blit && (sy_room < dy_room)) ? sy_room : dy_room;

   assign clip_w = (rect_width < COORD_W'(x_room))  ? rect_width[DIM_W-1:0]  : x_room;
   assign clip_h = (rect_height < COORD_W'(y_room)) ? rect_height[DIM_W-1:0] : y_room;

   assign clip_w_m1 = clip_w - DIM_W'(1);
   assign clip_h_m1 = clip_h - DIM_W'(1);

   // classify: what gets queued and in which form
   always_comb begin
      cmd.op        = OP_FILL;
      cmd.dest_x    = dest_x[X_W-1:0];
      cmd.dest_y    = dest_y[Y_W-1:0];
      cmd.source_x  = source_x[X_W-1:0];
      cmd.source_y  = source_y[Y_W-1:0];
      cmd.width_m1  = clip_w_m1[X_W-1:0];
      cmd.height_m1 = clip_h_m1[Y_W-1:0];
      cmd.rows_up   = 1'b0;
      cmd.cols_left = 1'b0;
      cmd.read_zero = !dest_in;
      cmd.color     = fill_color;
      keep          = 1'b0;
      unique case (mode)
         MODE_FILL: begin
            cmd.op = OP_FILL;
            keep   = dest_in && (clip_w != '0) && (clip_h != '0);
         end
         MODE_BLIT: begin
            cmd.op        = OP_BLIT;
            cmd.rows_up   = dest_y > source_y;
            cmd.cols_left = dest_x > source_x;
            keep          = dest_in && src_in && (clip_w != '0) && (clip_h != '0);
         end
         MODE_READ: begin
            cmd.op = OP_READ;
            keep   = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = accept && keep;

endmodule
`default_nettype wire

>>> hw/rtl/crfb_queue.sv
`default_nettype none
module crfb_queue
   import crfb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/crfb_back.sv
`default_nettype none
module crfb_back
   import crfb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [DIM_W-1:0]   surface_width,
   input  wire logic               head_valid,
   input  wire cmd_type            head_cmd,
   output logic                    pop,
   output back_status_type         status,
   output logic                    rsp_valid,
   output logic      [PIXEL_W-1:0] rsp_pixel_value
);

   localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_WIDTH);

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [X_W-1:0]     col_ff, col_in;
   logic [Y_W-1:0]     row_ff, row_in;
   logic [X_W-1:0]     col_cnt_ff, col_cnt_in;
   logic [Y_W-1:0]     row_cnt_ff, row_cnt_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]  wr_addr_ff, wr_addr_in;
   logic               rsp_pend_ff, rsp_pend_in;
   logic               rsp_zero_ff, rsp_zero_in;

   logic [DIM_W-1:0]   w_eff;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [PIXEL_W-1:0] ram_wdata, ram_rdata;
   logic [ADDR_W-1:0]  dest_addr, src_addr, head_addr;
   logic               last_col, last_pix;

   assign w_eff = (surface_width > MAX_W) ? MAX_W : surface_width;

   // entry of pixel (x, y) at stride w
   function automatic logic [ADDR_W-1:0] pix_addr(input logic [X_W-1:0] x,
                                                  input logic [Y_W-1:0] y,
                                                  input logic [DIM_W-1:0] w);
      logic [Y_W+DIM_W-1:0] prod;
      logic [Y_W+DIM_W-1:0] sum;
      prod = (Y_W + DIM_W)'(y) * (Y_W + DIM_W)'(w);
      sum  = prod + (Y_W + DIM_W)'(x);
      return sum[ADDR_W-1:0];
   endfunction

   assign dest_addr = pix_addr(cmd_ff.dest_x + col_ff, cmd_ff.dest_y + row_ff, w_eff);
   assign src_addr  = pix_addr(cmd_ff.source_x + col_ff, cmd_ff.source_y + row_ff, w_eff);
   assign head_addr = pix_addr(head_cmd.dest_x, head_cmd.dest_y, w_eff);

   assign last_col = (col_cnt_ff == '0);
   assign last_pix = last_col && (row_cnt_ff == '0);

   // sequencer: clear sweep, then one pixel per cycle per command
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      col_cnt_in  = col_cnt_ff;
      row_cnt_in  = row_cnt_ff;
      clr_addr_in = clr_addr_ff;
      wr_pend_in  = 1'b0;
      wr_addr_in  = wr_addr_ff;
      rsp_pend_in = 1'b0;
      rsp_zero_in = rsp_zero_ff;
      pop         = 1'b0;
      ram_we      = wr_pend_ff;
      ram_waddr   = wr_addr_ff;
      ram_wdata   = ram_rdata;
      ram_raddr   = src_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = BLACK_OPAQUE;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // a pending blit write drains before the next command
            if (head_valid && !wr_pend_ff) begin
               pop        = 1'b1;
               cmd_in     = head_cmd;
               col_in     = head_cmd.cols_left ? head_cmd.width_m1 : '0;
               row_in     = head_cmd.rows_up ? head_cmd.height_m1 : '0;
               col_cnt_in = head_cmd.width_m1;
               row_cnt_in = head_cmd.height_m1;
               unique case (head_cmd.op)
                  OP_FILL: state_in = ST_FILL;
                  OP_BLIT: state_in = ST_BLIT;
                  OP_READ: begin
                     ram_raddr   = head_addr;
                     rsp_pend_in = 1'b1;
                     rsp_zero_in = head_cmd.read_zero;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = dest_addr;
            ram_wdata = cmd_ff.color;
         end
         ST_BLIT: begin
            // read source now, write destination next cycle
            ram_raddr  = src_addr;
            wr_pend_in = 1'b1;
            wr_addr_in = dest_addr;
         end
         default: state_in = ST_IDLE;
      endcase

      // walk the clipped rectangle
      if ((state_ff == ST_FILL) || (state_ff == ST_BLIT)) begin
         if (last_pix) begin
            state_in = ST_IDLE;
         end else if (!last_col) begin
            col_cnt_in = col_cnt_ff - X_W'(1);
            col_in     = cmd_ff.cols_left ? col_ff - X_W'(1) : col_ff + X_W'(1);
         end else begin
            col_cnt_in = cmd_ff.width_m1;
            col_in     = cmd_ff.cols_left ? cmd_ff.width_m1 : '0;
            row_cnt_in = row_cnt_ff - Y_W'(1);
            row_in     = cmd_ff.rows_up ? row_ff - Y_W'(1) : row_ff + Y_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         wr_pend_ff  <= 1'b0;
         rsp_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         wr_pend_ff  <= wr_pend_in;
         rsp_pend_ff <= rsp_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      col_cnt_ff  <= col_cnt_in;
      row_cnt_ff  <= row_cnt_in;
      wr_addr_ff  <= wr_addr_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   crfb_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid       = rsp_pend_ff;
   assign rsp_pixel_value = rsp_zero_ff ? '0 : ram_rdata;

endmodule
`default_nettype wire

>>> hw/rtl/clipped_rect_fill_blit_engine_top.sv
// Rectangle fill / copy / pixel read engine over a 64K-word ARGB store. After reset the store
// is swept to opaque black, one word per cycle, with busy high; register writes are taken
// during the sweep. A command is taken when start is high and busy low; it is clipped on
// entry and placed in a 4-entry queue unless clipping leaves a fill or blit with nothing to do,
// and busy is high only while the sweep runs or that queue is full. The pixel sequencer works
// through the queue with the single-port-pair store as the limit: it takes a command off the
// queue in a step of its own, then a fill writes the clipped rectangle and a blit copies it,
// each blit write landing from a register so the last one drains before the next command is
// taken; a read needs only the step that takes it. A read's word appears on rsp_pixel_value for
// exactly one cycle with rsp_valid, the cycle after the sequencer takes it from the queue;
// the receiver cannot stall it, so sample it then. Commands complete in order, so a read sees
// every earlier fill and blit.
`default_nettype none
module clipped_rect_fill_blit_engine_top
   import crfb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // command channel
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_mode,
   input  wire logic [COORD_W-1:0] req_dest_x,
   input  wire logic [COORD_W-1:0] req_dest_y,
   input  wire logic [COORD_W-1:0] req_source_x,
   input  wire logic [COORD_W-1:0] req_source_y,
   input  wire logic [COORD_W-1:0] req_rect_width,
   input  wire logic [COORD_W-1:0] req_rect_height,
   input  wire logic [PIXEL_W-1:0] req_fill_color,
   // result channel
   output logic                    rsp_valid,
   output logic      [PIXEL_W-1:0] rsp_pixel_value,
   // register port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic      [31:0]        prdata,
   output logic                    pready
);

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;
   localparam logic [DIM_W-1:0] RESET_DIM = DIM_W'(256);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             reg_write;

   logic             accept, push, pop, full, head_valid;
   cmd_type          push_cmd, head_cmd;
   back_status_type  back_status;

   // register port
   assign pready    = 1'b1;
   assign reg_write = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (reg_write) begin
         unique case (paddr[2])
            REG_WIDTH:  width_in  = pwdata[DIM_W-1:0];
            REG_HEIGHT: height_in = pwdata[DIM_W-1:0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_DIM;
         height_ff <= RESET_DIM;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_ff) : 32'(width_ff);

   // command word handshake
   assign busy   = back_status.clearing || full;
   assign accept = start && !busy;

   crfb_front u_front (
      .accept         (accept),
      .mode           (req_mode),
      .dest_x         (req_dest_x),
      .dest_y         (req_dest_y),
      .source_x       (req_source_x),
      .source_y       (req_source_y),
      .rect_width     (req_rect_width),
      .rect_height    (req_rect_height),
      .fill_color     (req_fill_color),
      .surface_width  (width_ff),
      .surface_height (height_ff),
      .push           (push),
      .cmd            (push_cmd)
   );

   crfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   crfb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .surface_width   (width_ff),
      .head_valid      (head_valid),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .status          (back_status),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_value (rsp_pixel_value)
   );

endmodule
`default_nettype wire
